// ----- sv/dfs_pkg.sv -----
// Shared types and constants of the drive fault supervisor.
package dfs_pkg;

  // Supervisor state codes
  localparam logic [2:0] ST_BOOT    = 3'd0;
  localparam logic [2:0] ST_INIT    = 3'd1;
  localparam logic [2:0] ST_STANDBY = 3'd2;
  localparam logic [2:0] ST_RUN     = 3'd3;
  localparam logic [2:0] ST_FAULT   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_QUICK_RESET = 2'd0;
  localparam logic [1:0] REG_COMM_FIRST  = 2'd1;
  localparam logic [1:0] REG_COMM_LAST   = 2'd2;
  localparam logic [1:0] REG_SELF_TEST   = 2'd3;

  // Event kinds
  typedef enum logic [2:0] {
    KIND_INIT    = 3'd0,
    KIND_SERVICE = 3'd1,
    KIND_FAULT   = 3'd2,
    KIND_CLEAR   = 3'd3,
    KIND_RUN     = 3'd4,
    KIND_STANDBY = 3'd5,
    KIND_CONSUME = 3'd6,
    KIND_QUERY   = 3'd7
  } kind_e;

  // Configuration register set
  typedef struct packed {
    logic        quick_reset_mode;
    logic [15:0] comm_fault_first;
    logic [15:0] comm_fault_last;
    logic [15:0] self_test_fault_code;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic        accepted;
    logic [2:0]  state_code;
    logic        is_running;
    logic        is_faulted;
    logic [15:0] latched_fault;
    logic [31:0] latched_fault_time;
    logic [31:0] time_in_state;
    logic        pwm_disable_taken;
    logic        gate_pull_low;
    logic        run_latch;
  } res_t;

endpackage

// ----- sv/dfs_cfg.sv -----
// Configuration register file of the drive fault supervisor.
module dfs_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  output dfs_pkg::cfg_t cfg_o
);
  import dfs_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_QUICK_RESET: cfg_d.quick_reset_mode     = cfg_data_i[0];
        REG_COMM_FIRST:  cfg_d.comm_fault_first     = cfg_data_i;
        REG_COMM_LAST:   cfg_d.comm_fault_last      = cfg_data_i;
        REG_SELF_TEST:   cfg_d.self_test_fault_code = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quick_reset_mode     <= 1'b0;
      cfg_q.comm_fault_first     <= 16'd0;
      cfg_q.comm_fault_last      <= 16'd0;
      cfg_q.self_test_fault_code <= 16'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/dfs_core.sv -----
// Supervisor state machine with its result register.
module dfs_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dfs_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    kind_i,
  input  logic [31:0]   now_tick_i,
  input  logic          diag_fault_i,
  input  logic [15:0]   fault_code_in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dfs_pkg::res_t res_o
);
  import dfs_pkg::*;

  logic [2:0]  state_q, state_d;
  logic [15:0] first_fault_q, first_fault_d;
  logic [31:0] fault_time_q, fault_time_d;
  logic [31:0] entry_time_q, entry_time_d;
  logic [31:0] duration_q, duration_d;
  logic        run_q, run_d;
  logic        pwm_pend_q, pwm_pend_d;
  logic        out_valid_q;
  res_t        res_q, res_d;
  logic        in_fire;
  logic        accepted, taken, gate;
  logic        clearable;
  kind_e       kind;

  assign kind       = kind_e'(kind_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Latched code inside the comm range, or quick reset on
  assign clearable = cfg_i.quick_reset_mode ||
                     ((first_fault_q >= cfg_i.comm_fault_first) &&
                      (first_fault_q <= cfg_i.comm_fault_last));

  // Next state for the incoming event
  always_comb begin
    state_d       = state_q;
    first_fault_d = first_fault_q;
    fault_time_d  = fault_time_q;
    entry_time_d  = entry_time_q;
    duration_d    = duration_q;
    run_d         = run_q;
    pwm_pend_d    = pwm_pend_q;
    accepted      = 1'b0;
    taken         = 1'b0;
    gate          = 1'b0;
    unique case (kind)
      KIND_INIT: begin
        state_d       = ST_BOOT;
        first_fault_d = 16'd0;
        fault_time_d  = 32'd0;
        entry_time_d  = now_tick_i;
        duration_d    = 32'd0;
        run_d         = 1'b0;
        pwm_pend_d    = 1'b0;
      end
      KIND_SERVICE: begin
        duration_d = now_tick_i - entry_time_q;
        if (state_q == ST_BOOT) begin
          state_d      = ST_INIT;
          entry_time_d = now_tick_i;
        end else if (state_q == ST_INIT) begin
          if (!diag_fault_i) begin
            state_d      = ST_STANDBY;
            entry_time_d = now_tick_i;
          end
        end else if (state_q > ST_FAULT) begin
          // illegal state code: self-test fault, no gate pulse
          state_d       = ST_FAULT;
          first_fault_d = cfg_i.self_test_fault_code;
          fault_time_d  = now_tick_i;
          entry_time_d  = now_tick_i;
        end
      end
      KIND_FAULT: begin
        if (fault_code_in_i != 16'd0 && state_q != ST_FAULT) begin
          gate          = 1'b1;
          state_d       = ST_FAULT;
          first_fault_d = fault_code_in_i;
          fault_time_d  = now_tick_i;
          entry_time_d  = now_tick_i;
          pwm_pend_d    = 1'b1;
        end
      end
      KIND_CLEAR: begin
        if (state_q == ST_FAULT && clearable) begin
          state_d       = ST_STANDBY;
          first_fault_d = 16'd0;
          fault_time_d  = 32'd0;
          entry_time_d  = 32'd0;
          pwm_pend_d    = 1'b0;
          accepted      = 1'b1;
        end
      end
      KIND_RUN: begin
        if (state_q == ST_STANDBY) begin
          state_d      = ST_RUN;
          entry_time_d = now_tick_i;
          run_d        = 1'b1;
          accepted     = 1'b1;
        end
      end
      KIND_STANDBY: begin
        if (state_q == ST_RUN) begin
          state_d      = ST_STANDBY;
          entry_time_d = now_tick_i;
          run_d        = 1'b0;
          accepted     = 1'b1;
        end
      end
      KIND_CONSUME: begin
        taken      = pwm_pend_q;
        pwm_pend_d = 1'b0;
      end
      KIND_QUERY: begin
        accepted = 1'b0;
      end
      default: begin
        accepted = 1'b0;
      end
    endcase
  end

  // Result item built from the post-event state
  always_comb begin
    res_d.accepted           = accepted;
    res_d.state_code         = state_d;
    res_d.is_running         = (state_d == ST_RUN);
    res_d.is_faulted         = (state_d == ST_FAULT);
    res_d.latched_fault      = first_fault_d;
    res_d.latched_fault_time = fault_time_d;
    res_d.time_in_state      = duration_d;
    res_d.pwm_disable_taken  = taken;
    res_d.gate_pull_low      = gate;
    res_d.run_latch          = run_d;
  end

  // Supervisor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_BOOT;
      first_fault_q <= 16'd0;
      fault_time_q  <= 32'd0;
      entry_time_q  <= 32'd0;
      duration_q    <= 32'd0;
      run_q         <= 1'b0;
      pwm_pend_q    <= 1'b0;
    end else if (in_fire) begin
      state_q       <= state_d;
      first_fault_q <= first_fault_d;
      fault_time_q  <= fault_time_d;
      entry_time_q  <= entry_time_d;
      duration_q    <= duration_d;
      run_q         <= run_d;
      pwm_pend_q    <= pwm_pend_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // state register only ever holds a defined code
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q <= ST_FAULT)
    else $error("state register holds an undefined code");

  // a gate pulse goes out only with a fault state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.gate_pull_low |-> res_q.state_code == ST_FAULT)
    else $error("gate pulse without fault state");

  // a nonzero fault report always leaves the block faulted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && kind == KIND_FAULT && fault_code_in_i != 16'd0 |=> state_q == ST_FAULT)
    else $error("fault report did not reach fault state");

  // run flag rises only on an accepted run request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(run_q) |-> $past(in_fire) && $past(kind == KIND_RUN))
    else $error("run flag set without run request");

  // a consume event always clears the pending disable request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && kind == KIND_CONSUME |=> !pwm_pend_q)
    else $error("disable request still pending after consume");
`endif

endmodule

// ----- sv/drive_fault_supervisor_fsm.sv -----
// Top level of the drive fault supervisor.
//
// Usage:
//   Events enter on the in_ channel (valid/ready): kind_i, now_tick_i,
//   diag_fault_i and fault_code_in_i. Each accepted item yields exactly one
//   result item on the out_ channel (valid/ready), showing the supervisor
//   state after that event, the latched fault, its time, time in state and
//   the accepted / pwm_disable_taken / gate_pull_low flags.
//   The result of an accepted item is registered and valid in the next cycle.
//   Throughput is one item per cycle while each result is taken; a single
//   compare, subtract and update sit between state and result registers.
//   When the receiver stalls, the result register holds its item and
//   in_ready_o drops until the result is taken; in the cycle it is taken a
//   new item may enter.
//   Configuration registers are written on the cfg_ channel (always ready),
//   by the user only while no event is in flight; not enforced by the block.
//   Reset puts the supervisor in boot with no fault latched, all times zero,
//   the run flag and disable request clear, and the registers at defaults
//   (self-test fault code 1, all others 0).
module drive_fault_supervisor_fsm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] now_tick_i,
  input  logic        diag_fault_i,
  input  logic [15:0] fault_code_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [2:0]  state_code_o,
  output logic        is_running_o,
  output logic        is_faulted_o,
  output logic [15:0] latched_fault_o,
  output logic [31:0] latched_fault_time_o,
  output logic [31:0] time_in_state_o,
  output logic        pwm_disable_taken_o,
  output logic        gate_pull_low_o,
  output logic        run_latch_o
);
  import dfs_pkg::*;

  cfg_t cfg;
  res_t res;

  // Configuration registers
  dfs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Supervisor and result register
  dfs_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .now_tick_i      (now_tick_i),
    .diag_fault_i    (diag_fault_i),
    .fault_code_in_i (fault_code_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .res_o           (res)
  );

  // Result fields
  assign accepted_o           = res.accepted;
  assign state_code_o         = res.state_code;
  assign is_running_o         = res.is_running;
  assign is_faulted_o         = res.is_faulted;
  assign latched_fault_o      = res.latched_fault;
  assign latched_fault_time_o = res.latched_fault_time;
  assign time_in_state_o      = res.time_in_state;
  assign pwm_disable_taken_o  = res.pwm_disable_taken;
  assign gate_pull_low_o      = res.gate_pull_low;
  assign run_latch_o          = res.run_latch;

endmodule
